// ===== design/periodic_tick_event_table_unit_macros.svh =====
// Assertion shorthands shared by the event table RTL.
// Each one samples on aclk and is off while aresetn is low.
`ifndef PERIODIC_TICK_EVENT_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TICK_EVENT_TABLE_UNIT_MACROS_SVH

// Condition that holds at every edge
`define PTET_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Consequence in the same cycle
`define PTET_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the next cycle
`define PTET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptet_pkg.sv =====
package ptet_pkg;

    // Field widths
    localparam int TICK_W   = 32;
    localparam int ID_W     = 16;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 2;
    localparam int DIV_CNT_W = $clog2(TICK_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TICK_W - 1);

    // Input commands
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_INSTALL   = 2'd1,
        CMD_CHANGE    = 2'd2,
        CMD_UNINSTALL = 2'd3
    } cmd_t;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSTALLED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;

    // One table entry as stored in the slot RAM
    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [PERIOD_W-1:0] period;
    } slot_t;

    // Source of the result loaded into the output register
    typedef enum logic [1:0] {
        OUT_PEND_MID,
        OUT_PEND_LAST,
        OUT_INSTALLED,
        OUT_FULL
    } out_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_T_RD,
        ST_T_LOAD,
        ST_T_DIV,
        ST_T_CHECK,
        ST_EMIT_MID,
        ST_FLUSH,
        ST_INSTALL,
        ST_F_RD,
        ST_F_CHK,
        ST_S_RD,
        ST_S_WR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     latch_in;
        logic     tick_inc;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_en;
        logic     rd_next;
        logic     div_start;
        logic     div_step;
        logic     pend_set;
        logic     pend_clear;
        logic     out_load;
        out_sel_t out_sel;
        logic     wr_append;
        logic     wr_change;
        logic     wr_shift;
        logic     count_dec;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t in_cmd;
        logic idx_at_end;
        logic idx_last;
        logic table_full;
        logic div_done;
        logic rem_zero;
        logic period_zero;
        logic id_match;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/periodic_tick_event_table_unit.sv =====
// Periodic tick event table.
// Input channel s_*: one transaction per command. s_tuser carries the command
// (tick, install, change interval, uninstall), s_tdata the target id and the
// interval. Result channel m_*: m_tuser is the event kind, m_tdata the slot id,
// m_tlast marks the final result of a command.
// One command is processed at a time; s_tready is high only while idle.
// A tick walks the occupied slots in table order, reading each from the slot
// RAM and computing the tick count modulo its interval with a bit-serial
// remainder unit; slots with a zero interval are skipped. A tick can also wait
// on the result channel. Install appends a slot unless the table is full;
// change and uninstall search the table slot by slot, and uninstall then
// moves each later slot down by one place.
// A fired slot is held back until the next one is found or the walk ends, so
// that the last result can be marked.
// Reset clears the tick count, the id counter, the slot count and the output
// valid; slot RAM contents are not cleared. When the receiver stalls, the
// result stays in the output register and the walk waits for it to drain.
module periodic_tick_event_table_unit #(
    parameter int MAX_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] target_id, [31:16] interval
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] slot_id_out
    output logic [1:0]  m_tuser,   // [1:0] event_kind
    output logic        m_tlast
);

    import ptet_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    ptet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ptet_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== design/ptet_ram.sv =====
module ptet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while idle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ptet_ctrl.sv =====
module ptet_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output ptet_pkg::ctrl_cmd_t  cmd,
    input  ptet_pkg::dp_status_t stat
);

    import ptet_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_PEND_MID;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.in_cmd)
                    CMD_TICK: begin
                        cmd.tick_inc   = 1'b1;
                        cmd.idx_clear  = 1'b1;
                        cmd.pend_clear = 1'b1;
                        state_next     = ST_T_RD;
                    end
                    CMD_INSTALL: begin
                        state_next = ST_INSTALL;
                    end
                    default: begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_F_RD;
                    end
                endcase
            end
            // Walk the table, one slot per remainder
            ST_T_RD: begin
                if (stat.idx_at_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_T_LOAD;
                end
            end
            ST_T_LOAD: begin
                if (stat.period_zero) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_T_RD;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_T_DIV;
                end
            end
            ST_T_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_T_CHECK;
                end
            end
            ST_T_CHECK: begin
                if (stat.rem_zero && stat.pend_valid) begin
                    state_next = ST_EMIT_MID;
                end else begin
                    cmd.pend_set = stat.rem_zero;
                    cmd.idx_inc  = 1'b1;
                    state_next   = ST_T_RD;
                end
            end
            // Release the held result, keep the new one back for last marking
            ST_EMIT_MID: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PEND_MID;
                    cmd.pend_set = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = ST_T_RD;
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OUT_PEND_LAST;
                    cmd.pend_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_INSTALL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.table_full) begin
                        cmd.out_sel = OUT_FULL;
                    end else begin
                        cmd.out_sel   = OUT_INSTALLED;
                        cmd.wr_append = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            // Search for the first slot with the target id
            ST_F_RD: begin
                if (stat.idx_at_end) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK: begin
                if (!stat.id_match) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_F_RD;
                end else if (stat.in_cmd == CMD_CHANGE) begin
                    cmd.wr_change = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_S_RD;
                end
            end
            // Close up the table behind the removed slot
            ST_S_RD: begin
                if (stat.idx_last) begin
                    cmd.count_dec = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_S_WR;
                end
            end
            ST_S_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = ST_S_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ptet_datapath.sv =====
`include "periodic_tick_event_table_unit_macros.svh"

module ptet_datapath #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            s_tuser,
    input  logic [31:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  ptet_pkg::ctrl_cmd_t   cmd,
    output ptet_pkg::dp_status_t  stat
);

    import ptet_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SLOTS);

    // Latched transaction
    cmd_t                cmd_reg;
    logic [ID_W-1:0]     target_reg;
    logic [PERIOD_W-1:0] interval_reg;

    // Table state
    logic [TICK_W-1:0]   tick_count_reg;
    logic [ID_W-1:0]     next_id_reg;
    logic [CW-1:0]       slot_count_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_plus1;

    // Remainder unit
    logic [TICK_W-1:0]   dividend_reg;
    logic [PERIOD_W-1:0] divisor_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PERIOD_W:0]   rem_shift;
    logic [PERIOD_W:0]   rem_diff;

    // Fired slot held back until the next one or the end of the walk
    logic                pend_valid_reg;
    logic [ID_W-1:0]     pend_id_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic                out_last_reg;
    logic                out_free;

    // RAM ports
    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    slot_t               ram_wr_data;
    logic [IW-1:0]       ram_rd_addr;
    slot_t               ram_rd_data;

    assign idx_plus1 = idx_reg + CW'(1);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Capture the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg      <= cmd_t'(s_tuser);
            target_reg   <= s_tdata[15:0];
            interval_reg <= s_tdata[31:16];
        end
    end

    // Counters and table occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            next_id_reg    <= '0;
            slot_count_reg <= '0;
            idx_reg        <= '0;
        end else begin
            if (cmd.tick_inc) begin
                tick_count_reg <= tick_count_reg + TICK_W'(1);
            end
            if (cmd.wr_append) begin
                next_id_reg    <= next_id_reg + ID_W'(1);
                slot_count_reg <= slot_count_reg + CW'(1);
            end else if (cmd.count_dec) begin
                slot_count_reg <= slot_count_reg - CW'(1);
            end
            if (cmd.idx_clear) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_plus1;
            end
        end
    end

    // Slot RAM write mux
    always_comb begin
        ram_wr_en   = cmd.wr_append || cmd.wr_change || cmd.wr_shift;
        ram_wr_addr = idx_reg[IW-1:0];
        ram_wr_data = ram_rd_data;
        if (cmd.wr_append) begin
            ram_wr_addr        = slot_count_reg[IW-1:0];
            ram_wr_data.ident  = next_id_reg;
            ram_wr_data.period = interval_reg;
        end else if (cmd.wr_change) begin
            ram_wr_data.period = interval_reg;
        end
    end

    assign ram_rd_addr = cmd.rd_next ? idx_plus1[IW-1:0] : idx_reg[IW-1:0];

    ptet_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Restoring remainder, one dividend bit per cycle
    assign rem_shift = {rem_reg, dividend_reg[TICK_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dividend_reg <= tick_count_reg;
            divisor_reg  <= ram_rd_data.period;
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[TICK_W-2:0], 1'b0};
            div_cnt_reg  <= div_cnt_reg + DIV_CNT_W'(1);
            if (!rem_diff[PERIOD_W]) begin
                rem_reg <= rem_diff[PERIOD_W-1:0];
            end else begin
                rem_reg <= rem_shift[PERIOD_W-1:0];
            end
        end
    end

    // Held fired slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.pend_set) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.pend_clear) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_set) begin
            pend_id_reg <= ram_rd_data.ident;
        end
    end

    // Output register: load a result or drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OUT_PEND_MID: begin
                    out_kind_reg <= KIND_FIRED;
                    out_id_reg   <= pend_id_reg;
                    out_last_reg <= 1'b0;
                end
                OUT_PEND_LAST: begin
                    out_kind_reg <= KIND_FIRED;
                    out_id_reg   <= pend_id_reg;
                    out_last_reg <= 1'b1;
                end
                OUT_INSTALLED: begin
                    out_kind_reg <= KIND_INSTALLED;
                    out_id_reg   <= next_id_reg;
                    out_last_reg <= 1'b1;
                end
                default: begin
                    out_kind_reg <= KIND_FULL;
                    out_id_reg   <= '0;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Status back to the controller
    always_comb begin
        stat.in_cmd      = cmd_reg;
        stat.idx_at_end  = (idx_reg == slot_count_reg);
        stat.idx_last    = (idx_plus1 == slot_count_reg);
        stat.table_full  = (slot_count_reg == COUNT_MAX);
        stat.div_done    = (div_cnt_reg == DIV_LAST);
        stat.rem_zero    = (rem_reg == '0);
        stat.period_zero = (ram_rd_data.period == '0);
        stat.id_match    = (ram_rd_data.ident == target_reg);
        stat.pend_valid  = pend_valid_reg;
        stat.out_free    = out_free;
    end

    `PTET_ASSERT_ALWAYS(a_count_bound, slot_count_reg <= COUNT_MAX, "slot count above table size")
    `PTET_ASSERT_IMPLIES(a_no_append_full, cmd.wr_append, slot_count_reg != COUNT_MAX, "append into full table")
    `PTET_ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, out_free, "result overwritten before taken")
    `PTET_ASSERT_NEXT(a_rem_below_div, cmd.div_start || cmd.div_step, rem_reg < divisor_reg, "remainder not below interval")

endmodule
